>>> sv/spd_pkg.sv
package spd_pkg;

  localparam int MAX_PARTIALS_DEF = 64;
  localparam int CURVE_DEPTH_DEF  = 512;

  localparam int BARK_W   = 16;
  localparam int LOUD_W   = 16;
  localparam int CUTOFF_W = 12;
  localparam int WSUM_W   = 48;
  localparam int WT_W     = 32;
  localparam int Q_W      = 16;
  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 12'd1229;

  // Register index as decoded from paddr[2].
  localparam logic REG_IDX_CUTOFF = 1'b0;

  // Curve generation constants: exp(-1/32) in Q32 and e squared in Q16.
  localparam logic [63:0] STEP_Q32 = 64'd4162825044;
  localparam logic [63:0] ESQ_Q16  = 64'd484249;

  typedef struct packed {
    logic signed [BARK_W-1:0] bark_position;
    logic [LOUD_W-1:0]        loudness;
    logic                     is_last;
  } in_t;

  typedef struct packed {
    logic [Q_W-1:0]     total_dissonance;
    logic [COUNT_W-1:0] partial_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [BARK_W-1:0] bark;
    logic [LOUD_W-1:0] loud;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t a;
    entry_t b;
  } pair_req_t;

endpackage

>>> sv/spd_cell.sv
module spd_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  spd_pkg::entry_t d_in,
  output spd_pkg::entry_t d_out
);
  import spd_pkg::*;

  entry_t data_r;

  // The cell takes its neighbour's partial whenever the row moves.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

>>> sv/spd_pair.sv
module spd_pair #(
  parameter int CURVE_DEPTH = spd_pkg::CURVE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spd_pkg::pair_req_t             req,
  input  logic [spd_pkg::CUTOFF_W-1:0]   cutoff,
  input  logic                           clear,
  output logic                           busy,
  output logic [spd_pkg::WSUM_W-1:0]     wsum,
  output logic [spd_pkg::WT_W-1:0]       wt
);
  import spd_pkg::*;

  localparam int IDX_W = $clog2(CURVE_DEPTH);
  localparam int W_W   = LOUD_W + 1;
  localparam int P_W   = Q_W + W_W;

  typedef logic [Q_W-1:0] curve_tab_t [CURVE_DEPTH];

  function automatic curve_tab_t build_curve();
    curve_tab_t  tab;
    logic [63:0] e;
    logic [63:0] t;
    logic [63:0] v;
    e = 64'd1 << 32;
    for (int k = 0; k < CURVE_DEPTH; k++) begin
      t = (e * ESQ_Q16) >> 16;
      v = (64'(k) * 64'(k) * t + (64'd1 << 27)) >> 28;
      tab[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      e = (e * STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam curve_tab_t CURVE = build_curve();

  logic signed [BARK_W:0] diff;
  logic [BARK_W-1:0]      iv;
  logic                   hit;
  logic [IDX_W-1:0]       idx;
  logic [W_W-1:0]         w;

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             s1_hit_r, s2_hit_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [W_W-1:0]   s1_w_r, s2_w_r, s3_w_r;
  logic [Q_W-1:0]   rom_r;
  logic [P_W-1:0]   prod_r;
  logic [Q_W-1:0]   curve_val;

  logic [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [WT_W-1:0]   wt_r, wt_nxt;
  logic [WSUM_W:0]   wsum_add;
  logic [WT_W:0]     wt_add;

  always_comb begin
    diff = $signed({req.a.bark[BARK_W-1], req.a.bark})
         - $signed({req.b.bark[BARK_W-1], req.b.bark});
    iv   = diff[BARK_W] ? BARK_W'(-diff) : diff[BARK_W-1:0];
    hit  = (iv < {{(BARK_W-CUTOFF_W){1'b0}}, cutoff})
        && ({2'b00, iv[BARK_W-1:2]} < BARK_W'(CURVE_DEPTH));
    idx  = hit ? iv[IDX_W+1:2] : '0;
    w    = {1'b0, req.a.loud} + {1'b0, req.b.loud};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    s1_hit_r <= hit;
    s1_idx_r <= idx;
    s1_w_r   <= w;
    rom_r    <= CURVE[s1_idx_r];
    s2_hit_r <= s1_hit_r;
    s2_w_r   <= s1_w_r;
    prod_r   <= {{W_W{1'b0}}, curve_val} * {{Q_W{1'b0}}, s2_w_r};
    s3_w_r   <= s2_w_r;
  end

  assign curve_val = s2_hit_r ? rom_r : '0;

  // Both sums only grow, so saturating in any pair order gives the same total.
  always_comb begin
    wsum_add = {1'b0, wsum_r} + (WSUM_W+1)'(prod_r);
    wt_add   = {1'b0, wt_r} + (WT_W+1)'(s3_w_r);
    wsum_nxt = wsum_r;
    wt_nxt   = wt_r;
    if (clear) begin
      wsum_nxt = '0;
      wt_nxt   = '0;
    end else if (s3_v_r) begin
      wsum_nxt = wsum_add[WSUM_W] ? {WSUM_W{1'b1}} : wsum_add[WSUM_W-1:0];
      wt_nxt   = wt_add[WT_W] ? {WT_W{1'b1}} : wt_add[WT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      wt_r   <= '0;
    end else begin
      wsum_r <= wsum_nxt;
      wt_r   <= wt_nxt;
    end
  end

  assign busy = s1_v_r | s2_v_r | s3_v_r;
  assign wsum = wsum_r;
  assign wt   = wt_r;

endmodule

>>> sv/spd_div.sv
module spd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spd_pkg::WSUM_W-1:0] dividend,
  input  logic [spd_pkg::WT_W-1:0]   divisor,
  output logic                       done,
  output logic [spd_pkg::Q_W-1:0]    quotient
);
  import spd_pkg::*;

  localparam int CNT_W = $clog2(WSUM_W);

  logic              busy_r;
  logic              done_r;
  logic              zero_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WT_W-1:0]   rem_r;
  logic [WSUM_W-1:0] quo_r;
  logic [WT_W-1:0]   dvs_r;
  logic [WT_W:0]     shifted;
  logic [WT_W+1:0]   trial;

  // One restoring step per cycle: the dividend shifts out of the quotient
  // register into the remainder as quotient bits shift in.
  always_comb begin
    shifted = {rem_r, quo_r[WSUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WSUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      rem_r <= trial[WT_W+1] ? shifted[WT_W-1:0] : trial[WT_W-1:0];
      quo_r <= {quo_r[WSUM_W-2:0], ~trial[WT_W+1]};
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0
                  : (quo_r[WSUM_W-1:Q_W] != '0) ? {Q_W{1'b1}} : quo_r[Q_W-1:0];

endmodule

>>> sv/spectral_pairwise_dissonance.sv
// Spectral pairwise dissonance: partials of one spectrum arrive as input
// transactions (signed Q5.10 bark position, unsigned Q8.8 loudness, end-of-spectrum
// mark) and are held in a row of MAX_PARTIALS cells. For each partial the row is
// rotated once round, so every stored partial passes the single pair unit at the
// tail of the row and is paired with the newcomer; the newcomer is then paired
// with itself and shifted into the head cell. Each partial thus holds the block
// from acceptance until the full rotation of the cell row is done and the pair
// pipeline has drained; only then can the next be taken. A partial that arrives
// with the row full is dropped and raises the overflow flag. On the partial
// marked last, a restoring divider forms weighted sum over total weight, one
// quotient bit a cycle, and the result transaction is then offered; a zero total
// weight gives zero and the quotient saturates at 65535. A finished result waits
// in its own output register, so the next spectrum may start while it is still
// untaken. interval_cutoff lives at byte address 0 of the APB port, resets to
// 1229 and should be written only while the block is idle. There is no clearing
// pass after reset.
module spectral_pairwise_dissonance #(
  parameter int MAX_PARTIALS = spd_pkg::MAX_PARTIALS_DEF,
  parameter int CURVE_DEPTH  = spd_pkg::CURVE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  spd_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output spd_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spd_pkg::ADDR_W-1:0]  paddr,
  input  logic [spd_pkg::DATA_W-1:0]  pwdata,
  output logic [spd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import spd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PARTIALS + 1);
  localparam int STEP_W = $clog2(MAX_PARTIALS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_SELF,
    S_DRAIN,
    S_DIVIDE,
    S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                flag_r, flag_nxt;
  logic                last_r, last_nxt;
  entry_t              new_r, new_nxt;
  logic [COUNT_W-1:0]  pend_count_r, pend_count_nxt;
  logic                pend_flag_r, pend_flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  logic [CUTOFF_W-1:0] cutoff_r;

  logic                accept;
  logic                occupied;
  logic                div_start;
  logic                shift_en;
  entry_t              cell0_in;
  entry_t              cell_q [MAX_PARTIALS];
  pair_req_t           req;
  logic                pair_busy;
  logic [WSUM_W-1:0]   wsum;
  logic [WT_W-1:0]     wt;
  logic                div_done;
  logic [Q_W-1:0]      div_q;
  logic                cfg_wr;

  // The configuration register: a write completes in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_wr && (paddr[2] == REG_IDX_CUTOFF)) begin
      cutoff_r <= pwdata[CUTOFF_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_CUTOFF)
                ? {{(DATA_W-CUTOFF_W){1'b0}}, cutoff_r} : '0;

  // The row of cells. Stored partials sit contiguously from the head cell on;
  // during a rotation the tail cell feeds the head, and on insertion the new
  // partial enters the head while the (empty) tail entry falls off.
  for (genvar i = 0; i < MAX_PARTIALS; i++) begin : g_cell
    if (i == 0) begin : g_head
      spd_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell0_in),
        .d_out    (cell_q[i])
      );
    end else begin : g_body
      spd_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[i-1]),
        .d_out    (cell_q[i])
      );
    end
  end

  // At rotation step j the tail holds the partial that started in cell
  // MAX_PARTIALS-1-j, which is a stored one once j + count reaches the depth.
  assign occupied = ((CNT_W+1)'(step_r) + (CNT_W+1)'(count_r))
                  >= (CNT_W+1)'(MAX_PARTIALS);

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    flag_nxt       = flag_r;
    last_nxt       = last_r;
    new_nxt        = new_r;
    pend_count_nxt = pend_count_r;
    pend_flag_nxt  = pend_flag_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    div_start      = 1'b0;
    shift_en       = 1'b0;
    cell0_in       = cell_q[MAX_PARTIALS-1];
    req            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.bark = in_data.bark_position;
          new_nxt.loud = in_data.loudness;
          last_nxt     = in_data.is_last;
          if (count_r < CNT_W'(MAX_PARTIALS)) begin
            step_nxt  = '0;
            state_nxt = S_FEED;
          end else if (in_data.is_last) begin
            // Spectrum full and ending: the dropped partial still closes it.
            div_start      = 1'b1;
            pend_count_nxt = COUNT_W'(count_r);
            pend_flag_nxt  = 1'b1;
            count_nxt      = '0;
            flag_nxt       = 1'b0;
            state_nxt      = S_DIVIDE;
          end else begin
            flag_nxt = 1'b1;
          end
        end
      end
      S_FEED: begin
        shift_en  = 1'b1;
        req.valid = occupied;
        req.a     = cell_q[MAX_PARTIALS-1];
        req.b     = new_r;
        step_nxt  = step_r + 1'b1;
        if (step_r == STEP_W'(MAX_PARTIALS - 1)) begin
          state_nxt = S_SELF;
        end
      end
      S_SELF: begin
        shift_en  = 1'b1;
        cell0_in  = new_r;
        req.valid = 1'b1;
        req.a     = new_r;
        req.b     = new_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!pair_busy) begin
          if (last_r) begin
            div_start      = 1'b1;
            pend_count_nxt = COUNT_W'(count_r);
            pend_flag_nxt  = flag_r;
            count_nxt      = '0;
            flag_nxt       = 1'b0;
            state_nxt      = S_DIVIDE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // The quotient stays put in the divider until the output register frees.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.total_dissonance = div_q;
          out_data_nxt.partial_count    = pend_count_r;
          out_data_nxt.overflow         = pend_flag_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    last_r       <= last_nxt;
    new_r        <= new_nxt;
    pend_count_r <= pend_count_nxt;
    pend_flag_r  <= pend_flag_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sums are handed to the divider and cleared at the same edge.
  spd_pair #(
    .CURVE_DEPTH (CURVE_DEPTH)
  ) u_pair (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .cutoff (cutoff_r),
    .clear  (div_start),
    .busy   (pair_busy),
    .wsum   (wsum),
    .wt     (wt)
  );

  spd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum),
    .divisor  (wt),
    .done     (div_done),
    .quotient (div_q)
  );

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pair_busy)
    else $error("pair pipeline still busy while the block accepts partials");

  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !pair_busy)
    else $error("division started before all pairs were accumulated");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PARTIALS))
    else $error("stored partial count exceeds the cell row");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SELF) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insertion did not advance the stored count");

endmodule
